>>> src/ec_key_hysteresis_debounce_defines.svh
// Assertion helpers for the key debounce block.
`ifndef EC_KEY_HYSTERESIS_DEBOUNCE_DEFINES_SVH
`define EC_KEY_HYSTERESIS_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, checked while not in reset.
`define EKHD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ekhd assertion failed");

// Next-cycle implication, checked while not in reset.
`define EKHD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ekhd assertion failed");

`endif

>>> src/ekhd_pkg.sv
package ekhd_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ekhd_state_t;

  localparam logic [1:0] CFG_PRESS_THRESHOLD   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE_TIME     = 2'd2;

  localparam logic signed [12:0] PRESS_THRESHOLD_RST   = 13'sd120;
  localparam logic signed [12:0] RELEASE_THRESHOLD_RST = 13'sd80;
  localparam logic [7:0]         DEBOUNCE_TIME_RST     = 8'd5;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_CALIB = 1'b1;

  typedef struct packed {
    logic signed [12:0] press_threshold;
    logic signed [12:0] release_threshold;
    logic [7:0]         debounce_time;
  } ekhd_cfg_t;

endpackage

>>> src/ekhd_mem.sv
module ekhd_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 65,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

>>> src/ekhd_update.sv
module ekhd_update #(
  parameter int CALIB_COUNT = 16,
  localparam int CW = (CALIB_COUNT > 1) ? $clog2(CALIB_COUNT) : 1,
  localparam int EW = 12 + 1 + 32 + 16 + CW
) (
  input  ekhd_pkg::ekhd_cfg_t cfg,
  input  logic                cmd,
  input  logic [11:0]         sample,
  input  logic [31:0]         now_ms,
  input  logic [EW-1:0]       ent_rd,
  output logic [EW-1:0]       ent_wr,
  output logic                pressed,
  output logic                changed
);
  import ekhd_pkg::*;

  // Exact floor division of a 16-bit sum by a constant via a 25-bit reciprocal.
  localparam int DIV_SHIFT = 24;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + CALIB_COUNT - 1) / CALIB_COUNT;
  localparam logic [24:0] RECIP = 25'(RECIP_VAL);

  logic [11:0]        base_old;
  logic               down_old;
  logic [31:0]        time_old;
  logic [15:0]        sum_old;
  logic [CW-1:0]      cnt_old;
  logic [11:0]        base_new;
  logic               down_new;
  logic [31:0]        time_new;
  logic [15:0]        sum_new;
  logic [CW-1:0]      cnt_new;

  logic [15:0]        sum_add;
  logic [CW:0]        cnt_inc;
  logic [40:0]        prod;
  logic signed [12:0] delta;
  logic [31:0]        elapsed;
  logic               want;

  assign {base_old, down_old, time_old, sum_old, cnt_old} = ent_rd;
  assign ent_wr = {base_new, down_new, time_new, sum_new, cnt_new};

  assign sum_add = sum_old + {4'd0, sample};
  assign cnt_inc = {1'b0, cnt_old} + (CW+1)'(1);
  assign prod    = {25'd0, sum_add} * {16'd0, RECIP};
  assign delta   = $signed({1'b0, sample}) - $signed({1'b0, base_old});
  assign elapsed = now_ms - time_old;

  always_comb begin
    want = down_old;
    if (!down_old && (delta >= cfg.press_threshold)) begin
      want = 1'b1;
    end else if (down_old && (delta <= cfg.release_threshold)) begin
      want = 1'b0;
    end
  end

  always_comb begin
    base_new = base_old;
    down_new = down_old;
    time_new = time_old;
    sum_new  = sum_old;
    cnt_new  = cnt_old;
    changed  = 1'b0;
    if (cmd == CMD_CALIB) begin
      if (cnt_inc >= (CW+1)'(CALIB_COUNT)) begin
        base_new = prod[DIV_SHIFT +: 12];
        down_new = 1'b0;
        time_new = '0;
        sum_new  = '0;
        cnt_new  = '0;
      end else begin
        sum_new = sum_add;
        cnt_new = cnt_inc[CW-1:0];
      end
    end else begin
      if (want != down_old) begin
        if (elapsed >= {24'd0, cfg.debounce_time}) begin
          down_new = want;
          time_new = now_ms;
          changed  = 1'b1;
        end
      end else begin
        time_new = now_ms;
      end
    end
    pressed = down_new;
  end

endmodule

>>> src/ec_key_hysteresis_debounce.sv
// Flow: the per-key state memory is read on an input transfer; the result is
// registered once the output register is free, and the updated state is written
// back at the same time. Ready stays low until then, so only one item is in flight.
// Reset: synchronous; thresholds and debounce time return to 120, 80 and 5,
// and every key entry reads as zero until written again.
module ec_key_hysteresis_debounce #(
  parameter int KEY_COUNT   = 128,
  parameter int CALIB_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // key_index[6:0], sample[18:7], now_ms[50:19], zero pad
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // key_out[6:0], pressed[7], changed[8], zero pad
);
  import ekhd_pkg::*;

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CW = (CALIB_COUNT > 1) ? $clog2(CALIB_COUNT) : 1;
  localparam int EW = 12 + 1 + 32 + 16 + CW;

  ekhd_state_t state, state_next;
  ekhd_cfg_t   cfg;

  logic          cmd_q;
  logic [6:0]    key_q;
  logic [11:0]   smp_q;
  logic [31:0]   now_q;

  logic          in_xfer;
  logic          out_free;
  logic          mem_we;
  logic          out_load;
  logic          key_ok;
  logic [AW+6:0] rd_key_wide;
  logic [AW+6:0] wr_key_wide;
  logic [EW-1:0] ent_rd;
  logic [EW-1:0] ent_wr;
  logic          upd_pressed;
  logic          upd_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold   <= PRESS_THRESHOLD_RST;
      cfg.release_threshold <= RELEASE_THRESHOLD_RST;
      cfg.debounce_time     <= DEBOUNCE_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PRESS_THRESHOLD:   cfg.press_threshold   <= cfg_wdata;
        CFG_RELEASE_THRESHOLD: cfg.release_threshold <= cfg_wdata;
        CFG_DEBOUNCE_TIME:     cfg.debounce_time     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_xfer) state_next = ST_EXEC;
      ST_EXEC: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q <= s_tuser[0];
      key_q <= s_tdata[6:0];
      smp_q <= s_tdata[18:7];
      now_q <= s_tdata[50:19];
    end
  end

  assign rd_key_wide = {{AW{1'b0}}, s_tdata[6:0]};
  assign wr_key_wide = {{AW{1'b0}}, key_q};
  assign key_ok      = {2'b00, key_q} < 9'(KEY_COUNT);
  // Hold the state of an out-of-range key untouched.
  assign mem_we      = out_load && key_ok;

  ekhd_mem #(
    .DEPTH (KEY_COUNT),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .rd_addr (rd_key_wide[AW-1:0]),
    .rd_data (ent_rd),
    .wr_en   (mem_we),
    .wr_addr (wr_key_wide[AW-1:0]),
    .wr_data (ent_wr)
  );

  ekhd_update #(
    .CALIB_COUNT (CALIB_COUNT)
  ) u_update (
    .cfg     (cfg),
    .cmd     (cmd_q),
    .sample  (smp_q),
    .now_ms  (now_q),
    .ent_rd  (ent_rd),
    .ent_wr  (ent_wr),
    .pressed (upd_pressed),
    .changed (upd_changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, upd_changed && key_ok, upd_pressed && key_ok, key_q};
    end
  end

endmodule

>>> src/ekhd_checker.sv
`include "ec_key_hysteresis_debounce_defines.svh"

module ekhd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result holds.
  `EKHD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Drop ready for the update cycle after every input transfer.
  `EKHD_ASSERT_NEXT(a_in_interlock, clk, rst, s_tvalid && s_tready, !s_tready)
  // Every input transfer is followed by a presented result; a stalled one holds.
  `EKHD_ASSERT_NOW(a_result_due, clk, rst, s_tvalid && s_tready, ##2 m_tvalid)

endmodule

bind ec_key_hysteresis_debounce ekhd_checker u_checker (.*);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ekhd_pkg::*;

  localparam int KEYS        = 128;
  localparam int CAL_SAMPLES = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [6:0] key;
    logic       pressed;
    logic       changed;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_PRESS_THRESHOLD;
  logic [12:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // key_index[6:0], sample[18:7], now_ms[50:19], zero pad
  logic [0:0]  s_tuser = '0;   // cmd[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // key_out[6:0], pressed[7], changed[8], zero pad

  ec_key_hysteresis_debounce u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Key tracking state, mirrored from the block's behaviour
  logic signed [12:0] press_lvl    = PRESS_THRESHOLD_RST;
  logic signed [12:0] release_lvl  = RELEASE_THRESHOLD_RST;
  logic [7:0]         debounce_lvl = DEBOUNCE_TIME_RST;
  logic [11:0]        base_lvl  [KEYS];
  logic               key_dn    [KEYS];
  logic [31:0]        stable_ms [KEYS];
  logic [15:0]        cal_sum   [KEYS];
  int                 cal_cnt   [KEYS];

  key_result_t debounced_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic [31:0] ms_now = '0;
  logic [6:0]  key_pool [8];

  initial begin
    for (int i = 0; i < KEYS; i++) begin
      base_lvl[i]  = '0;
      key_dn[i]    = 1'b0;
      stable_ms[i] = '0;
      cal_sum[i]   = '0;
      cal_cnt[i]   = 0;
    end
  end

  // Advance the debounced state of one key and queue the result it gives
  task automatic settle_key(input logic cmd, input logic [6:0] key, input logic [11:0] smp,
                            input logic [31:0] now);
    key_result_t r;
    int          delta;
    logic        want;
    logic [31:0] elapsed;
    r.key     = key;
    r.changed = 1'b0;
    if (cmd == CMD_CALIB) begin
      cal_sum[key] = cal_sum[key] + 16'(smp);
      cal_cnt[key]++;
      if (cal_cnt[key] >= CAL_SAMPLES) begin
        base_lvl[key]  = 12'(cal_sum[key] / CAL_SAMPLES);
        cal_sum[key]   = '0;
        cal_cnt[key]   = 0;
        key_dn[key]    = 1'b0;
        stable_ms[key] = '0;
      end
    end else begin
      delta = int'(smp) - int'(base_lvl[key]);
      want  = key_dn[key];
      if (!key_dn[key] && delta >= int'(press_lvl))
        want = 1'b1;
      else if (key_dn[key] && delta <= int'(release_lvl))
        want = 1'b0;
      if (want != key_dn[key]) begin
        elapsed = now - stable_ms[key];
        if (elapsed >= {24'd0, debounce_lvl}) begin
          key_dn[key]    = want;
          stable_ms[key] = now;
          r.changed      = 1'b1;
        end
      end else begin
        stable_ms[key] = now;
      end
    end
    r.pressed = key_dn[key];
    debounced_q.push_back(r);
  endtask

  task automatic send_item(input logic cmd, input logic [6:0] key, input logic [11:0] smp,
                           input logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'd0, now, smp, key};
    s_tuser  = cmd;
    do @(posedge clk); while (!s_tready);
    settle_key(cmd, key, smp, now);
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (debounced_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [12:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      CFG_PRESS_THRESHOLD:   press_lvl    = data;
      CFG_RELEASE_THRESHOLD: release_lvl  = data;
      CFG_DEBOUNCE_TIME:     debounce_lvl = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int press, input int release_v, input int deb);
    write_reg(CFG_PRESS_THRESHOLD, 13'(press));
    write_reg(CFG_RELEASE_THRESHOLD, 13'(release_v));
    write_reg(CFG_DEBOUNCE_TIME, {5'd0, 8'(deb)});
  endtask

  function automatic logic [11:0] clip12(input int v);
    if (v < 0)
      return 12'd0;
    if (v > 4095)
      return 12'd4095;
    return 12'(v);
  endfunction

  // Mostly hover around the threshold the key is currently facing
  function automatic logic [11:0] probe_sample(input logic [6:0] k);
    int thr;
    int mode;
    thr  = key_dn[k] ? int'(release_lvl) : int'(press_lvl);
    mode = $urandom_range(99);
    if (mode < 60)
      return clip12(int'(base_lvl[k]) + thr + $urandom_range(6) - 3);
    if (mode < 85)
      return clip12(int'(base_lvl[k]) + thr + $urandom_range(600) - 300);
    return 12'($urandom_range(4095));
  endfunction

  task automatic calib_burst(input logic [6:0] k);
    int level;
    int pick;
    pick  = $urandom_range(9);
    level = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(4095);
    for (int j = 0; j < CAL_SAMPLES; j++) begin
      send_item(CMD_CALIB, k, clip12(level + $urandom_range(40) - 20), ms_now);
      ms_now += $urandom_range(1);
    end
  endtask

  task automatic refill_pool();
    foreach (key_pool[i])
      key_pool[i] = 7'($urandom_range(KEYS - 1));
  endtask

  task automatic run_traffic(input int n_items);
    logic [6:0] k;
    int         pick;
    int         sent;
    sent = 0;
    while (sent < n_items) begin
      k    = ($urandom_range(99) < 10) ? 7'($urandom_range(KEYS - 1))
                                       : key_pool[$urandom_range(7)];
      pick = $urandom_range(99);
      if (pick < 2) begin
        calib_burst(k);
        sent += CAL_SAMPLES;
      end else begin
        if (pick < 8)
          send_item(CMD_CALIB, k, 12'($urandom_range(4095)), ms_now);
        else
          send_item(CMD_SCAN, k, probe_sample(k), ms_now);
        sent++;
      end
      if ($urandom_range(99) == 0)
        ms_now = $urandom();
      else
        ms_now += $urandom_range(3);
    end
  endtask

  task automatic test_directed_cases();
    // press through the wrap of the millisecond counter, then bounce on release
    send_item(CMD_SCAN, 7'd127, 12'd4095, 32'hFFFF_FFFD);
    send_item(CMD_SCAN, 7'd127, 12'd0,    32'h0000_0001);
    send_item(CMD_SCAN, 7'd127, 12'd0,    32'h0000_0002);
    send_item(CMD_SCAN, 7'd127, 12'd4095, 32'h0000_0003);
    send_item(CMD_SCAN, 7'd127, 12'd100,  32'h0000_0004);
    // pressed key, then a full calibration must clear it
    send_item(CMD_SCAN, 7'd0, 12'd200, 32'd50);
    for (int j = 0; j < CAL_SAMPLES; j++)
      send_item(CMD_CALIB, 7'd0, (j % 2 == 0) ? 12'd4095 : 12'd0, 32'd60);
    // exactly on the thresholds against the new baseline
    send_item(CMD_SCAN, 7'd0, 12'd2167, 32'd100);
    send_item(CMD_SCAN, 7'd0, 12'd2127, 32'd110);
    wait_idle();
  endtask

  task automatic test_hysteresis_sweep();
    refill_pool();
    ms_now = 32'hFFFF_FF00;
    run_traffic(600);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    refill_pool();
    set_thresholds(4095, -4096, 255);
    run_traffic(150);
    wait_idle();
    set_thresholds(-4096, 4095, 0);
    run_traffic(150);
    wait_idle();
    set_thresholds(0, 0, 1);
    run_traffic(150);
    wait_idle();
    set_thresholds($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                   $urandom_range(31));
    run_traffic(150);
    wait_idle();
  endtask

  task automatic test_output_hold();
    refill_pool();
    set_thresholds(150, 60, 3);
    hold_req = ~hold_req;
    run_traffic(430);
    wait_idle();
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    int   stall_left;
    logic hold_seen;
    stall_left = 0;
    hold_seen  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    key_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (debounced_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual 0x%04h", $time, m_tdata);
        mismatches++;
      end else begin
        exp_r = debounced_q.pop_front();
        if (m_tdata[6:0] !== exp_r.key) begin
          $display("%0t: key_out expected %0d actual %0d", $time, exp_r.key, m_tdata[6:0]);
          mismatches++;
        end
        if (m_tdata[7] !== exp_r.pressed) begin
          $display("%0t: pressed (key %0d) expected %0b actual %0b", $time, exp_r.key,
                   exp_r.pressed, m_tdata[7]);
          mismatches++;
        end
        if (m_tdata[8] !== exp_r.changed) begin
          $display("%0t: changed (key %0d) expected %0b actual %0b", $time, exp_r.key,
                   exp_r.changed, m_tdata[8]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("** ec_key_hysteresis_debounce: FAILED **");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 55;
    test_directed_cases();
    test_hysteresis_sweep();

    send_idle_pct = 55;
    recv_idle_pct = 15;
    test_register_extremes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_hold();

    repeat (10) @(negedge clk);
    while (debounced_q.size() != 0) begin
      $display("%0t: missing result, expected key %0d pressed %0b changed %0b, actual none",
               $time, debounced_q[0].key, debounced_q[0].pressed, debounced_q[0].changed);
      void'(debounced_q.pop_front());
      mismatches++;
    end
    if (mismatches == 0)
      $display("** ec_key_hysteresis_debounce: PASSED **");
    else
      $display("** ec_key_hysteresis_debounce: FAILED **");
    $finish;
  end

endmodule
